### rtl/mat4i_pkg.sv
package mat4i_pkg;

  // Element format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Limb width of the shared multiplier (one element by one limb)
  localparam int LIMB_W = DATA_WIDTH;

  // Exact widths of the intermediate values
  localparam int MINOR_W = 2 * DATA_WIDTH + 1;
  localparam int COF_W   = DATA_WIDTH + MINOR_W + 2;
  localparam int DET_W   = DATA_WIDTH + COF_W + 2;
  localparam int NUM_W   = COF_W + 2 * FRAC_BITS;
  localparam int DEN_W   = DET_W;

  localparam int MINOR_LIMBS = (MINOR_W + LIMB_W - 1) / LIMB_W;
  localparam int COF_LIMBS   = (COF_W + LIMB_W - 1) / LIMB_W;
  localparam int LIMB_IW     = $clog2(COF_LIMBS);
  localparam int PROD_W      = DATA_WIDTH + LIMB_W + 1;
  localparam int CNT_W       = $clog2(NUM_W + 1);

  // Source of the multiplier's second operand
  typedef enum logic [1:0] {
    MS_ELEM,
    MS_MINOR,
    MS_COF
  } mat4i_mulsrc_t;

  // Accumulator written by the shared adder
  typedef enum logic [1:0] {
    AD_MINOR,
    AD_COF,
    AD_DET
  } mat4i_accdst_t;

  // Controller to datapath
  typedef struct packed {
    logic          load;
    logic          opa_ld;
    logic [3:0]    mat_addr;
    logic          mul_en;
    mat4i_mulsrc_t mul_src;
    logic [LIMB_IW-1:0] limb;
    logic          acc_en;
    mat4i_accdst_t acc_dst;
    logic          acc_clr;
    logic          acc_sub;
    logic          cof_wr;
    logic [3:0]    cof_addr;
    logic          div_start;
    logic          emit;
    logic [3:0]    out_idx;
  } mat4i_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic det_zero;
    logic div_done;
  } mat4i_stat_t;

  // n-th of the three indices left after dropping x
  function automatic logic [1:0] mat4i_skip(input logic [1:0] x, input logic [1:0] n);
    return (n >= x) ? n + 2'd1 : n;
  endfunction

  // Store address of a 2x2 minor operand for cofactor k, term j.
  // h picks the product (0: direct, 1: crossed), is_b the second factor.
  function automatic logic [3:0] mat4i_minor_addr(input logic [3:0] k, input logic [1:0] j,
                                                  input logic h, input logic is_b);
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] rr;
    logic [1:0] cc;
    p  = (j == 2'd0) ? 2'd1 : 2'd0;
    q  = (j == 2'd2) ? 2'd1 : 2'd2;
    rr = mat4i_skip(k[1:0], is_b ? 2'd2 : 2'd1);
    cc = mat4i_skip(k[3:2], (h ^ is_b) ? q : p);
    return {cc, rr};
  endfunction

  // Store address of the top-row element of term j of cofactor k
  function automatic logic [3:0] mat4i_term_addr(input logic [3:0] k, input logic [1:0] j);
    return {mat4i_skip(k[3:2], j), mat4i_skip(k[1:0], 2'd0)};
  endfunction

endpackage

### rtl/mat4i_div.sv
module mat4i_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mat4i_pkg::NUM_W-1:0] num,
  input  logic [mat4i_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [mat4i_pkg::NUM_W-1:0] quot
);
  import mat4i_pkg::*;

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] nq_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // One restoring step: shift in next dividend bit, trial subtract
  assign rem_sh = {rem_r, nq_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = !diff[DEN_W+1];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nq_r  <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nq_r  <= {nq_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule

### rtl/mat4i_dp.sv
module mat4i_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mat4i_pkg::mat4i_cmd_t                 cmd,
  input  logic [3:0]                            in_entry_index,
  input  logic signed [mat4i_pkg::DATA_WIDTH-1:0] in_entry_value,
  output mat4i_pkg::mat4i_stat_t                stat,
  output logic                                  out_valid,
  output logic [3:0]                            out_index,
  output logic signed [mat4i_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  out_saturated,
  output logic                                  out_singular,
  output logic                                  out_last
);
  import mat4i_pkg::*;

  logic signed [DATA_WIDTH-1:0] mat_r [16];
  logic signed [COF_W-1:0]      cof_mem [16];
  logic signed [DATA_WIDTH-1:0] opa_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [MINOR_W-1:0]    minor_r;
  logic signed [COF_W-1:0]      cofacc_r;
  logic signed [DET_W-1:0]      det_r;
  logic                         neg_r;

  logic                         out_valid_r;
  logic [3:0]                   out_index_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                         out_sat_r;
  logic                         out_sing_r;
  logic                         out_last_r;

  logic signed [DATA_WIDTH-1:0]          rd_elem;
  logic signed [COF_W-1:0]               cof_rd;
  logic signed [MINOR_LIMBS*LIMB_W-1:0]  minor_ext;
  logic signed [COF_LIMBS*LIMB_W-1:0]    cof_ext;
  logic [LIMB_W-1:0]                     limb_val;
  logic                                  limb_top;
  logic signed [LIMB_W:0]                opb;
  logic signed [DET_W-1:0]               addend;
  logic signed [DET_W-1:0]               base;
  logic signed [DET_W-1:0]               acc_sum;
  logic                                  det_neg;
  logic [DEN_W-1:0]                      den_mag;
  logic [COF_W-1:0]                      cof_abs;
  logic [NUM_W-1:0]                      num_mag;
  logic                                  div_done;
  logic [NUM_W-1:0]                      quot;
  logic [NUM_W-1:0]                      lim;
  logic [DATA_WIDTH-1:0]                 mag;
  logic [DATA_WIDTH-1:0]                 val;
  logic                                  big;

  assign rd_elem   = mat_r[cmd.mat_addr];
  assign cof_rd    = cof_mem[cmd.cof_addr];
  assign minor_ext = (MINOR_LIMBS*LIMB_W)'(minor_r);
  assign cof_ext   = (COF_LIMBS*LIMB_W)'(cof_rd);

  // Multiplier second operand: element or one limb of a wide value
  always_comb begin
    limb_val = '0;
    limb_top = 1'b0;
    opb      = '0;
    unique case (cmd.mul_src)
      MS_ELEM: begin
        opb = (LIMB_W+1)'(rd_elem);
      end
      MS_MINOR: begin
        limb_val = minor_ext[cmd.limb*LIMB_W +: LIMB_W];
        limb_top = cmd.limb == LIMB_IW'(MINOR_LIMBS - 1);
        opb      = {limb_top & limb_val[LIMB_W-1], limb_val};
      end
      MS_COF: begin
        limb_val = cof_ext[cmd.limb*LIMB_W +: LIMB_W];
        limb_top = cmd.limb == LIMB_IW'(COF_LIMBS - 1);
        opb      = {limb_top & limb_val[LIMB_W-1], limb_val};
      end
      default: opb = '0;
    endcase
  end

  // Shared adder: target +/- product shifted to its limb
  always_comb begin
    addend = DET_W'(prod_r) << (cmd.limb * LIMB_W);
    unique case (cmd.acc_dst)
      AD_MINOR: base = DET_W'(minor_r);
      AD_COF:   base = DET_W'(cofacc_r);
      AD_DET:   base = det_r;
      default:  base = '0;
    endcase
    if (cmd.acc_clr) begin
      base = '0;
    end
    acc_sum = cmd.acc_sub ? base - addend : base + addend;
  end

  // Matrix store, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
    end else if (cmd.load) begin
      mat_r[in_entry_index] <= in_entry_value;
    end
  end

  // Operand, product, accumulators and cofactor store
  always_ff @(posedge clk) begin
    if (cmd.opa_ld) begin
      opa_r <= rd_elem;
    end
    if (cmd.mul_en) begin
      prod_r <= opa_r * opb;
    end
    if (cmd.acc_en) begin
      unique case (cmd.acc_dst)
        AD_MINOR: minor_r  <= acc_sum[MINOR_W-1:0];
        AD_COF:   cofacc_r <= acc_sum[COF_W-1:0];
        AD_DET:   det_r    <= acc_sum;
        default:  det_r    <= det_r;
      endcase
    end
    if (cmd.cof_wr) begin
      cof_mem[cmd.cof_addr] <= cofacc_r;
    end
    if (cmd.div_start) begin
      neg_r <= cof_rd[COF_W-1] ^ det_neg;
    end
  end

  // Divider operands: magnitudes, numerator scaled by 2^(2F)
  assign det_neg = det_r[DET_W-1];
  assign den_mag = det_neg ? DEN_W'(-det_r) : DEN_W'(det_r);
  assign cof_abs = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : COF_W'(cof_rd);
  assign num_mag = {cof_abs, {(2*FRAC_BITS){1'b0}}};

  mat4i_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.det_zero = (det_r == '0);
  assign stat.div_done = div_done;

  // Saturate quotient and apply sign
  always_comb begin
    lim = (NUM_W'(1) << (DATA_WIDTH - 1)) - NUM_W'(!neg_r);
    big = quot > lim;
    mag = big ? lim[DATA_WIDTH-1:0] : quot[DATA_WIDTH-1:0];
    val = neg_r ? -mag : mag;
  end

  // Result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index_r <= cmd.out_idx;
      out_last_r  <= cmd.out_idx == 4'd15;
      out_sing_r  <= stat.det_zero;
      out_value_r <= stat.det_zero ? '0 : val;
      out_sat_r   <= !stat.det_zero && big;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_singular  = out_sing_r;
  assign out_last      = out_last_r;

endmodule

### rtl/mat4i_ctrl.sv
module mat4i_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_compute,
  input  mat4i_pkg::mat4i_stat_t stat,
  output logic                   busy,
  output mat4i_pkg::mat4i_cmd_t  cmd
);
  import mat4i_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_LA,
    ST_M_MB,
    ST_M_AC,
    ST_T_LA,
    ST_T_MB,
    ST_T_AC,
    ST_C_WR,
    ST_D_LA,
    ST_D_MB,
    ST_D_AC,
    ST_V_ST,
    ST_V_WT
  } state_t;

  state_t             state_r;
  logic [3:0]         k_r;
  logic [1:0]         j_r;
  logic               h_r;
  logic [LIMB_IW-1:0] l_r;

  logic [3:0] k_t;
  logic       term_sub;
  logic       l_minor_end;
  logic       l_cof_end;
  logic       emit_now;

  // Transposed index: inverse(row, col) takes cofactor(col, row)
  assign k_t         = {k_r[1:0], k_r[3:2]};
  // Middle term negative, then cofactor sign by row+col parity
  assign term_sub    = j_r[0] ^ k_r[0] ^ k_r[2];
  assign l_minor_end = l_r == LIMB_IW'(MINOR_LIMBS - 1);
  assign l_cof_end   = l_r == LIMB_IW'(COF_LIMBS - 1);
  assign emit_now    = (state_r == ST_V_ST && stat.det_zero) ||
                       (state_r == ST_V_WT && stat.div_done);
  assign busy        = state_r != ST_IDLE;

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.mul_src = MS_ELEM;
    cmd.acc_dst = AD_MINOR;
    cmd.load    = start && state_r == ST_IDLE;
    cmd.limb    = l_r;
    cmd.out_idx = k_r;
    cmd.emit    = emit_now;
    unique case (state_r)
      ST_M_LA: begin
        cmd.opa_ld   = 1'b1;
        cmd.mat_addr = mat4i_minor_addr(k_r, j_r, h_r, 1'b0);
      end
      ST_M_MB: begin
        cmd.mul_en   = 1'b1;
        cmd.mat_addr = mat4i_minor_addr(k_r, j_r, h_r, 1'b1);
      end
      ST_M_AC: begin
        cmd.acc_en  = 1'b1;
        cmd.limb    = '0;
        cmd.acc_clr = !h_r;
        cmd.acc_sub = h_r;
      end
      ST_T_LA: begin
        cmd.opa_ld   = 1'b1;
        cmd.mat_addr = mat4i_term_addr(k_r, j_r);
      end
      ST_T_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MS_MINOR;
      end
      ST_T_AC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_dst = AD_COF;
        cmd.acc_clr = j_r == 2'd0 && l_r == '0;
        cmd.acc_sub = term_sub;
      end
      ST_C_WR: begin
        cmd.cof_wr   = 1'b1;
        cmd.cof_addr = k_r;
      end
      ST_D_LA: begin
        cmd.opa_ld   = 1'b1;
        cmd.mat_addr = {2'b00, k_r[1:0]};
      end
      ST_D_MB: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_src  = MS_COF;
        cmd.cof_addr = {2'b00, k_r[1:0]};
      end
      ST_D_AC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_dst = AD_DET;
        cmd.acc_clr = k_r[1:0] == 2'd0 && l_r == '0;
      end
      ST_V_ST: begin
        cmd.cof_addr  = k_t;
        cmd.div_start = !stat.det_zero;
      end
      ST_V_WT: begin
        cmd.cof_addr = k_t;
      end
      default: begin
        cmd.mat_addr = '0;
      end
    endcase
  end

  // State and sequence counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      h_r     <= 1'b0;
      l_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          k_r <= '0;
          j_r <= '0;
          h_r <= 1'b0;
          l_r <= '0;
          if (start && in_compute) begin
            state_r <= ST_M_LA;
          end
        end
        ST_M_LA: state_r <= ST_M_MB;
        ST_M_MB: state_r <= ST_M_AC;
        ST_M_AC: begin
          h_r     <= !h_r;
          state_r <= h_r ? ST_T_LA : ST_M_LA;
        end
        ST_T_LA: begin
          l_r     <= '0;
          state_r <= ST_T_MB;
        end
        ST_T_MB: state_r <= ST_T_AC;
        ST_T_AC: begin
          if (l_minor_end) begin
            l_r <= '0;
            if (j_r == 2'd2) begin
              j_r     <= '0;
              state_r <= ST_C_WR;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= ST_M_LA;
            end
          end else begin
            l_r     <= l_r + LIMB_IW'(1);
            state_r <= ST_T_MB;
          end
        end
        ST_C_WR: begin
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd15) ? ST_D_LA : ST_M_LA;
        end
        ST_D_LA: begin
          l_r     <= '0;
          state_r <= ST_D_MB;
        end
        ST_D_MB: state_r <= ST_D_AC;
        ST_D_AC: begin
          if (l_cof_end) begin
            l_r <= '0;
            if (k_r[1:0] == 2'd3) begin
              k_r     <= '0;
              state_r <= ST_V_ST;
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= ST_D_LA;
            end
          end else begin
            l_r     <= l_r + LIMB_IW'(1);
            state_r <= ST_D_MB;
          end
        end
        ST_V_ST, ST_V_WT: begin
          if (emit_now) begin
            k_r     <= k_r + 4'd1;
            state_r <= (k_r == 4'd15) ? ST_IDLE : ST_V_ST;
          end else begin
            state_r <= ST_V_WT;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Divider completion only while waiting for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == ST_V_WT)
    else $error("divider finished outside wait state");

  // No division started on a singular matrix
  a_no_div_singular: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.det_zero)
    else $error("division started with zero determinant");

  // Run ends only right after the final result
  a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> $past(cmd.emit && cmd.out_idx == 4'd15))
    else $error("run ended without final result");

endmodule

### rtl/matrix4_inverse_core.sv
// 4x4 fixed-point matrix inverse. Each transaction (start high while busy is low) writes one
// signed Q16.16 element at in_entry_index (column*4+row). With in_compute set the element is
// stored and the block turns busy: it forms the sixteen 3x3 cofactors exactly on one shared
// 32x33 multiplier and wide adder, the determinant from column 0, then gives the sixteen
// inverse elements in index order. Each of these is one pass of a restoring divider at one
// quotient bit per cycle; with a zero determinant the results follow one per cycle with
// out_singular set and value zero. Results appear on out_* for exactly one cycle with
// out_valid high and cannot be held off; the receiver must take every one.
module matrix4_inverse_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [3:0]                            in_entry_index,
  input  logic signed [mat4i_pkg::DATA_WIDTH-1:0] in_entry_value,
  input  logic                                  in_compute,
  output logic                                  out_valid,
  output logic [3:0]                            out_index,
  output logic signed [mat4i_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  out_saturated,
  output logic                                  out_singular,
  output logic                                  out_last
);
  import mat4i_pkg::*;

  mat4i_cmd_t  cmd;
  mat4i_stat_t stat;

  // Sequencer
  mat4i_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_compute (in_compute),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  // Store, arithmetic and result register
  mat4i_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_index      (out_index),
    .out_value      (out_value),
    .out_saturated  (out_saturated),
    .out_singular   (out_singular),
    .out_last       (out_last)
  );

endmodule
